// File: rtl/kfwq_pkg.sv
package kfwq_pkg;

    typedef enum logic [2:0] {
        KIND_APPEND    = 3'd0,
        KIND_APPEND_EQ = 3'd1,
        KIND_REMOVE    = 3'd2,
        KIND_WAKE_ONE  = 3'd3,
        KIND_WAKE_KEY  = 3'd4,
        KIND_WAKE_ALL  = 3'd5,
        KIND_MARK_DEAD = 3'd6,
        KIND_COUNT     = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_CHANGED = 2'd1,
        ST_NONE    = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // decoded request as handed from front to back
    typedef struct packed {
        kind_t kind;
        logic  changed;
    } cmd_ctl_t;

endpackage

// File: rtl/kfwq_front.sv
module kfwq_front
    import kfwq_pkg::*;
#(
    parameter int ID_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [7:0]         waiter_id,
    input  logic [63:0]        match_key,
    input  logic signed [31:0] observed_value,
    input  logic signed [31:0] expected_value,
    output logic               cmd_valid,
    output cmd_ctl_t           cmd_ctl,
    output logic [ID_BITS-1:0] cmd_id,
    output logic [63:0]        cmd_key,
    input  logic               cmd_pop
);

    cmd_ctl_t           ctl_reg [2];
    logic [ID_BITS-1:0] id_reg  [2];
    logic [63:0]        key_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               push;
    cmd_ctl_t           new_ctl;

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_ctl   = ctl_reg[rd_ptr_reg];
    assign cmd_id    = id_reg[rd_ptr_reg];
    assign cmd_key   = key_reg[rd_ptr_reg];

    always_comb
    begin
        new_ctl.kind    = kind_t'(kind);
        new_ctl.changed = (observed_value != expected_value);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (cmd_pop && cmd_valid);
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, cmd_pop && cmd_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_reg[wr_ptr_reg] <= new_ctl;
            id_reg[wr_ptr_reg]  <= ID_BITS'(waiter_id);
            key_reg[wr_ptr_reg] <= match_key;
        end
    end

endmodule

// File: rtl/kfwq_back.sv
module kfwq_back
    import kfwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    localparam int PW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_ctl_t           cmd_ctl,
    input  logic [ID_BITS-1:0] cmd_id,
    input  logic [63:0]        cmd_key,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [7:0]         woken_id,
    output logic [4:0]         waiter_count,
    output logic               last,
    output logic [CW-1:0]      occ
);

    logic [ID_BITS-1:0]     ids_reg  [QUEUE_DEPTH];
    logic [ID_BITS-1:0]     ids_next [QUEUE_DEPTH];
    logic [63:0]            keys_reg  [QUEUE_DEPTH];
    logic [63:0]            keys_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] live_reg, live_next;
    logic [CW-1:0]          occ_reg, occ_next;

    logic                   out_valid_reg;
    status_t                status_reg;
    logic [7:0]             woken_reg;
    logic [4:0]             count_reg;
    logic                   last_reg;

    logic [QUEUE_DEPTH-1:0] cand;
    logic [QUEUE_DEPTH-1:0] other;
    logic                   hit;
    logic [PW-1:0]          hit_pos;
    logic                   go;
    logic                   emit;
    status_t                res_status;
    logic [7:0]             res_id;
    logic [4:0]             res_count;
    logic                   res_last;
    logic                   do_app, do_kill, do_drop, do_clear;

    assign occ          = occ_reg;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign woken_id     = woken_reg;
    assign waiter_count = count_reg;
    assign last         = last_reg;
    assign go           = cmd_valid && (!out_valid_reg || !out_stall);

    // per-cell match
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            case (cmd_ctl.kind)
                KIND_REMOVE:    cand[i] = (ids_reg[i] == cmd_id);
                KIND_MARK_DEAD: cand[i] = live_reg[i] && (ids_reg[i] == cmd_id);
                KIND_WAKE_KEY:  cand[i] = (keys_reg[i] == cmd_key);
                default:        cand[i] = 1'b1;
            endcase
            cand[i] = cand[i] && (CW'(i) < occ_reg);
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit     = 1'b1;
                hit_pos = PW'(i);
            end
        end
        other          = live_reg;
        other[hit_pos] = 1'b0;
    end

    always_comb
    begin
        emit       = 1'b0;
        cmd_pop    = 1'b0;
        res_status = ST_DONE;
        res_id     = 8'd0;
        res_count  = 5'd0;
        res_last   = 1'b1;
        do_app     = 1'b0;
        do_kill    = 1'b0;
        do_drop    = 1'b0;
        do_clear   = 1'b0;
        if (go)
        begin
            case (cmd_ctl.kind)
                KIND_APPEND, KIND_APPEND_EQ:
                begin
                    emit    = 1'b1;
                    cmd_pop = 1'b1;
                    if (cmd_ctl.kind == KIND_APPEND_EQ && cmd_ctl.changed)
                        res_status = ST_CHANGED;
                    else if (occ_reg == CW'(QUEUE_DEPTH))
                        res_status = ST_FULL;
                    else
                        do_app = 1'b1;
                end
                KIND_REMOVE:
                begin
                    emit       = 1'b1;
                    cmd_pop    = 1'b1;
                    do_drop    = hit;
                    res_status = hit ? ST_DONE : ST_NONE;
                end
                KIND_MARK_DEAD:
                begin
                    emit       = 1'b1;
                    cmd_pop    = 1'b1;
                    do_kill    = hit;
                    res_status = hit ? ST_DONE : ST_NONE;
                end
                KIND_COUNT:
                begin
                    emit      = 1'b1;
                    cmd_pop   = 1'b1;
                    res_count = 5'(occ_reg);
                end
                KIND_WAKE_ONE, KIND_WAKE_KEY, KIND_WAKE_ALL:
                begin
                    if (!hit)
                    begin
                        emit       = 1'b1;
                        cmd_pop    = 1'b1;
                        res_status = ST_NONE;
                    end
                    else
                    begin
                        // dead entries are dropped one a cycle while the output is not stalled, without a result
                        do_drop = 1'b1;
                        if (live_reg[hit_pos])
                        begin
                            emit   = 1'b1;
                            res_id = 8'(ids_reg[hit_pos]);
                            if (cmd_ctl.kind == KIND_WAKE_ALL)
                            begin
                                res_last = !(|other);
                                do_clear = res_last;
                            end
                            cmd_pop = res_last;
                        end
                    end
                end
                default:
                begin
                    emit    = 1'b1;
                    cmd_pop = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        ids_next  = ids_reg;
        keys_next = keys_reg;
        live_next = live_reg;
        occ_next  = occ_reg;
        if (do_app)
        begin
            ids_next[occ_reg[PW-1:0]]  = cmd_id;
            keys_next[occ_reg[PW-1:0]] = cmd_key;
            live_next[occ_reg[PW-1:0]] = 1'b1;
            occ_next                   = occ_reg + CW'(1);
        end
        if (do_kill)
            live_next[hit_pos] = 1'b0;
        if (do_drop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (PW'(i) >= hit_pos)
                begin
                    ids_next[i]  = ids_reg[i+1];
                    keys_next[i] = keys_reg[i+1];
                    live_next[i] = live_reg[i+1];
                end
            end
            live_next[QUEUE_DEPTH-1] = 1'b0;
            occ_next                 = occ_reg - CW'(1);
        end
        if (do_clear)
        begin
            live_next = '0;
            occ_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            occ_reg  <= occ_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ids_reg  <= ids_next;
        keys_reg <= keys_next;
        if (emit)
        begin
            status_reg <= res_status;
            woken_reg  <= res_id;
            count_reg  <= res_count;
            last_reg   <= res_last;
        end
    end

endmodule

// File: rtl/keyed_fifo_wait_queue.sv
// Ordered wait queue of (id, key, live) entries with key-matched wake.
// Input channel: in_valid/in_stall carry one request (kind, waiter_id,
// match_key, observed_value, expected_value). A request is taken at an edge
// with in_valid high and in_stall low; a two-entry request queue sits in
// front, so in_stall rises only when both slots hold pending requests.
// Output channel: out_valid/out_stall carry result items (status, woken_id,
// waiter_count, last) from an output register; last marks the final result
// of a request. Only wake all gives more than one result, one per woken entry.
// A request passes through the front queue and then the output register.
// Throughput: one request per cycle for append, remove, mark dead and count while
// the output is not stalled; a wake drops the dead entries it meets without a
// result, since the back end's match-and-compact step removes one cell per cycle.
// A stalled output holds its result and freezes the back end; requests keep
// filling the front queue until it is full.
// Reset empties the queue and the output register; it takes effect at once.
module keyed_fifo_wait_queue
    import kfwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [7:0]         waiter_id,
    input  logic [63:0]        match_key,
    input  logic signed [31:0] observed_value,
    input  logic signed [31:0] expected_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [7:0]         woken_id,
    output logic [4:0]         waiter_count,
    output logic               last
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic               cmd_valid;
    cmd_ctl_t           cmd_ctl;
    logic [ID_BITS-1:0] cmd_id;
    logic [63:0]        cmd_key;
    logic               cmd_pop;
    logic [CW-1:0]      occ;

    kfwq_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .waiter_id      (waiter_id),
        .match_key      (match_key),
        .observed_value (observed_value),
        .expected_value (expected_value),
        .cmd_valid      (cmd_valid),
        .cmd_ctl        (cmd_ctl),
        .cmd_id         (cmd_id),
        .cmd_key        (cmd_key),
        .cmd_pop        (cmd_pop)
    );

    kfwq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ctl      (cmd_ctl),
        .cmd_id       (cmd_id),
        .cmd_key      (cmd_key),
        .cmd_pop      (cmd_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .woken_id     (woken_id),
        .waiter_count (waiter_count),
        .last         (last),
        .occ          (occ)
    );

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= CW'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        occ > $past(occ) |-> occ == $past(occ) + CW'(1))
        else $error("occupancy grew by more than one");

    a_count_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && waiter_count != 5'd0 |-> status == ST_DONE && last)
        else $error("count on a non-done result");

    a_woken_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && woken_id != 8'd0 |-> status == ST_DONE)
        else $error("woken id on a non-done result");

endmodule

// File: tb/tb_keyed_fifo_wait_queue.sv
`timescale 1ns / 1ps

module tb_keyed_fifo_wait_queue;
    import kfwq_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        kind_t       kind;
        logic [7:0]  wid;
        logic [63:0] key;
        logic [31:0] obs;
        logic [31:0] exv;
        bit          hold;
    } request_t;

    typedef struct {
        status_t    st;
        logic [7:0] wid;
        logic [4:0] cnt;
        logic       lst;
    } wake_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] kind;
    logic [7:0] waiter_id;
    logic [63:0] match_key;
    logic signed [31:0] observed_value;
    logic signed [31:0] expected_value;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic [7:0] woken_id;
    logic [4:0] waiter_count;
    logic last;

    keyed_fifo_wait_queue DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .waiter_id(waiter_id), .match_key(match_key),
        .observed_value(observed_value), .expected_value(expected_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .woken_id(woken_id),
        .waiter_count(waiter_count), .last(last)
    );

    request_t     pending_reqs[$];
    wake_result_t expected_results[$];

    logic [7:0]  q_ids[DEPTH];
    logic [63:0] q_keys[DEPTH];
    bit          q_live[DEPTH];
    int          q_occ;

    int  mismatches;
    int  idle_pct;
    int  stall_pct;
    bit  draining;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void q_drop(int pos);
        for (int i = pos; i + 1 < q_occ; i++)
        begin
            q_ids[i]  = q_ids[i + 1];
            q_keys[i] = q_keys[i + 1];
            q_live[i] = q_live[i + 1];
        end
        q_occ--;
        q_live[q_occ] = 0;
    endfunction

    function automatic bit q_wake(bit by_key, logic [63:0] key, output logic [7:0] wid);
        int pos;
        pos = 0;
        wid = '0;
        while (pos < q_occ)
        begin
            if (by_key && q_keys[pos] != key)
                pos++;
            else if (q_live[pos])
            begin
                wid = q_ids[pos];
                q_drop(pos);
                return 1;
            end
            else
                q_drop(pos);
        end
        return 0;
    endfunction

    function automatic void push_result(status_t st, logic [7:0] wid, logic [4:0] cnt, logic lst);
        wake_result_t r;
        r.st = st;
        r.wid = wid;
        r.cnt = cnt;
        r.lst = lst;
        expected_results.push_back(r);
    endfunction

    function automatic status_t q_append(logic [7:0] wid, logic [63:0] key);
        if (q_occ >= DEPTH)
            return ST_FULL;
        q_ids[q_occ] = wid;
        q_keys[q_occ] = key;
        q_live[q_occ] = 1;
        q_occ++;
        return ST_DONE;
    endfunction

    function automatic void predict_queue(request_t rq);
        logic [7:0] wid;
        int n;
        bit hit;
        hit = 0;
        case (rq.kind)
            KIND_APPEND:
                push_result(q_append(rq.wid, rq.key), 0, 0, 1);
            KIND_APPEND_EQ:
                if (rq.obs != rq.exv)
                    push_result(ST_CHANGED, 0, 0, 1);
                else
                    push_result(q_append(rq.wid, rq.key), 0, 0, 1);
            KIND_REMOVE:
            begin
                for (int i = 0; i < q_occ && !hit; i++)
                    if (q_ids[i] == rq.wid)
                    begin
                        q_drop(i);
                        hit = 1;
                    end
                push_result(hit ? ST_DONE : ST_NONE, 0, 0, 1);
            end
            KIND_WAKE_ONE, KIND_WAKE_KEY:
                if (q_wake(rq.kind == KIND_WAKE_KEY, rq.key, wid))
                    push_result(ST_DONE, wid, 0, 1);
                else
                    push_result(ST_NONE, 0, 0, 1);
            KIND_WAKE_ALL:
            begin
                n = 0;
                while (n < DEPTH && q_wake(0, '0, wid))
                begin
                    push_result(ST_DONE, wid, 0, 0);
                    n++;
                end
                if (n == 0)
                    push_result(ST_NONE, 0, 0, 1);
                else
                    expected_results[$].lst = 1;
            end
            KIND_MARK_DEAD:
            begin
                for (int i = 0; i < q_occ && !hit; i++)
                    if (q_live[i] && q_ids[i] == rq.wid)
                    begin
                        q_live[i] = 0;
                        hit = 1;
                    end
                push_result(hit ? ST_DONE : ST_NONE, 0, 0, 1);
            end
            default:
                push_result(ST_DONE, 0, 5'(q_occ), 1);
        endcase
    endfunction

    function automatic void add_req(kind_t k, logic [7:0] wid, logic [63:0] key,
                                    logic [31:0] obs, logic [31:0] exv);
        request_t rq;
        rq.kind = k;
        rq.wid = wid;
        rq.key = key;
        rq.obs = obs;
        rq.exv = exv;
        rq.hold = 0;
        pending_reqs.push_back(rq);
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && pending_reqs[0].hold && expected_results.size() > 0)
                in_valid <= 1'b0;
            else if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                if (pending_reqs[0].hold)
                    pending_reqs[0].hold = 0;
                in_valid       <= 1'b1;
                kind           <= pending_reqs[0].kind;
                waiter_id      <= pending_reqs[0].wid;
                match_key      <= pending_reqs[0].key;
                observed_value <= pending_reqs[0].obs;
                expected_value <= pending_reqs[0].exv;
                predict_queue(pending_reqs[0]);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status=%0d id=%0d cnt=%0d last=%0d",
                                 status, woken_id, waiter_count, last);
                end
                else
                begin
                    wake_result_t e;
                    e = expected_results.pop_front();
                    if (status !== e.st || woken_id !== e.wid ||
                        waiter_count !== e.cnt || last !== e.lst)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st=%0d id=%0d cnt=%0d last=%0d,",
                                      " got st=%0d id=%0d cnt=%0d last=%0d"},
                                     e.st, e.wid, e.cnt, e.lst,
                                     status, woken_id, waiter_count, last);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct) && !draining;
        end
    end

    initial
    begin
        kind_t k;
        int r;
        logic [7:0] wid;
        logic [31:0] v;

        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        kind = '0;
        waiter_id = '0;
        match_key = '0;
        observed_value = '0;
        expected_value = '0;
        q_occ = 0;
        for (int i = 0; i < DEPTH; i++)
            q_live[i] = 0;
        mismatches = 0;
        idle_pct = 0;
        stall_pct = 0;
        draining = 0;

        // directed
        add_req(KIND_WAKE_ONE, 0, 0, 0, 0);
        add_req(KIND_WAKE_ALL, 0, 0, 0, 0);
        add_req(KIND_REMOVE, 8'd5, 0, 0, 0);
        add_req(KIND_MARK_DEAD, 8'd5, 0, 0, 0);
        add_req(KIND_APPEND, 8'h00, 64'h0, 0, 0);
        add_req(KIND_APPEND, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        add_req(KIND_APPEND_EQ, 8'h10, 64'h5, 32'h8000_0000, 32'h7FFF_FFFF);
        add_req(KIND_APPEND_EQ, 8'h11, 64'h5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(KIND_APPEND, 8'h11, 64'h5, 0, 0);
        add_req(KIND_MARK_DEAD, 8'h11, 0, 0, 0);
        add_req(KIND_COUNT, 0, 0, 0, 0);
        add_req(KIND_WAKE_KEY, 0, 64'h5, 0, 0);
        add_req(KIND_WAKE_KEY, 0, 64'h9, 0, 0);
        add_req(KIND_REMOVE, 8'hFF, 0, 0, 0);
        add_req(KIND_WAKE_ONE, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            add_req(KIND_APPEND, 8'(i), 64'(i & 3), 0, 0);
        add_req(KIND_APPEND_EQ, 8'h1, 0, 32'h1, 32'h2);
        add_req(KIND_APPEND_EQ, 8'h1, 0, 32'h3, 32'h3);
        add_req(KIND_MARK_DEAD, 8'd0, 0, 0, 0);
        add_req(KIND_COUNT, 0, 0, 0, 0);
        add_req(KIND_WAKE_ALL, 0, 0, 0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  <= (ph == 1 || ph == 3) ? (ph == 1 ? 62 : 23) : 0;
            stall_pct <= (ph == 2 || ph == 3) ? (ph == 2 ? 62 : 23) : 0;
            if (ph == 2)
            begin
                add_req(KIND_COUNT, 0, 0, 0, 0);
                pending_reqs[$].hold = 1;
            end
            for (int n = 0; n < 110; n++)
            begin
                r = $urandom_range(99);
                wid = 8'($urandom_range(7));
                if ($urandom_range(9) == 0)
                    wid = 8'($urandom());
                if (r < 35)
                    k = KIND_APPEND;
                else if (r < 45)
                    k = KIND_APPEND_EQ;
                else if (r < 53)
                    k = KIND_REMOVE;
                else if (r < 63)
                    k = KIND_WAKE_ONE;
                else if (r < 73)
                    k = KIND_WAKE_KEY;
                else if (r < 78)
                    k = KIND_WAKE_ALL;
                else if (r < 90)
                    k = KIND_MARK_DEAD;
                else
                    k = KIND_COUNT;
                v = $urandom();
                add_req(k, wid,
                        $urandom_range(1) ? 64'($urandom_range(3)) : rand_key(),
                        v, $urandom_range(1) ? v : $urandom());
            end
            while (pending_reqs.size() > 0)
                @(posedge clk);
        end
        while (expected_results.size() > 0)
            @(posedge clk);
        draining = 1;
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
